// File: hw/rtl/pedal_adc_median_conditioner_assert.svh
// Assertion macros for the pedal ADC median conditioner.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef PEDAL_ADC_MEDIAN_CONDITIONER_ASSERT_SVH
`define PEDAL_ADC_MEDIAN_CONDITIONER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PMC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pmc assertion failed");
`define PMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmc assertion failed");
`else
`define PMC_ASSERT(lbl, clk, rst_n, prop)
`define PMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/pmc_pkg.sv
// Shared types and constants of the pedal ADC median conditioner.
// No dependencies; imported by the interfaces and every module.
package pmc_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int VAL_W      = 7;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_INDEX_W = 2;

    localparam logic [VAL_W-1:0]      VALUE_MAX     = 7'd127;
    localparam logic [VAL_W-1:0]      REPORT_PERIOD = 7'd100;
    localparam logic [SAMPLE_W-1:0]   GAIN_RESET    = 12'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OFFSET,
        REG_GAIN,
        REG_INVERT,
        REG_REPORT_EN
    } pmc_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_COUNT,
        ST_QUAL,
        ST_PICK
    } pmc_state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } pmc_cell_ctrl_t;

endpackage

// File: hw/rtl/pmc_if.sv
// Valid/ready channel interfaces: raw samples in, conditioned results out.
// Depends on pmc_pkg for field widths.
interface pmc_sample_if;
    import pmc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pmc_result_if;
    import pmc_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] scaled;
    logic [VAL_W-1:0] median;
    logic             report;

    modport source (output valid, output scaled, output median, output report, input ready);
    modport sink   (input valid, input scaled, input median, input report, output ready);
endinterface

// File: hw/rtl/pedal_adc_median_conditioner.sv
// Pedal ADC median conditioner top level: config registers, control FSM,
// ring of pmc_cell, median pick, report logic and output register.
// Depends on pmc_pkg, pmc_if, pmc_scale, pmc_cell and the assertion header.
//
//  channel   | dir | transaction carries           | handshake
//  ----------+-----+-------------------------------+-------------------------
//  samples   | in  | sample[11:0]                  | valid & ready
//  results   | out | scaled[6:0] median[6:0] report| valid & ready
//  cfg       | in  | cfg_index, cfg_data           | cfg_we, no back-pressure
//
// From acceptance to result valid a sample passes through the scale/insert state,
// WINDOW_DEPTH rotations of the cell ring in the count state, the qualify state
// and the pick state.
// One sample is in flight at a time; a new one is taken while a result waits.
// A stalled result holds the pick state until the output register frees.
// Reset clears the window, history, counter, config and all control state.
`include "pedal_adc_median_conditioner_assert.svh"

module pedal_adc_median_conditioner #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    pmc_sample_if.sink                      samples,
    pmc_result_if.source                    results
);
    import pmc_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int HALF   = WINDOW_DEPTH / 2;

    // configuration
    logic [SAMPLE_W-1:0] offset_reg;
    logic [SAMPLE_W-1:0] gain_reg;
    logic                invert_reg;
    logic                report_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            gain_reg      <= GAIN_RESET;
            invert_reg    <= 1'b0;
            report_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (pmc_reg_t'(cfg_index))
                REG_OFFSET:    offset_reg    <= cfg_data[SAMPLE_W-1:0];
                REG_GAIN:      gain_reg      <= cfg_data[SAMPLE_W-1:0];
                REG_INVERT:    invert_reg    <= cfg_data[0];
                REG_REPORT_EN: report_en_reg <= cfg_data[0];
            endcase
        end
    end

    // control
    pmc_state_t     state_reg;
    pmc_state_t     state_next;
    logic [CNT_W-1:0] run_reg;
    logic [CNT_W-1:0] run_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    pmc_cell_ctrl_t cell_ctrl;
    logic           in_ready;
    logic           pick_fire;
    logic           out_free;
    logic           run_last;

    logic             out_valid_reg;
    logic [VAL_W-1:0] out_scaled_reg;
    logic [VAL_W-1:0] out_median_reg;
    logic             out_report_reg;

    assign out_free = !out_valid_reg || results.ready;
    assign run_last = (run_reg == CNT_W'(WINDOW_DEPTH - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (samples.valid) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_COUNT;
            ST_COUNT: if (run_last) state_next = ST_QUAL;
            ST_QUAL:  state_next = ST_PICK;
            ST_PICK:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        cell_ctrl.load  = (state_reg == ST_SCALE);
        cell_ctrl.shift = (state_reg == ST_COUNT);
        pick_fire       = (state_reg == ST_PICK) && out_free;
    end

    always_comb
    begin
        run_next  = run_reg;
        slot_next = slot_reg;
        if (cell_ctrl.load)
        begin
            run_next  = '0;
            slot_next = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        end
        else if (cell_ctrl.shift)
            run_next = run_last ? '0 : run_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            run_reg   <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            slot_reg  <= slot_next;
        end
    end

    assign samples.ready = in_ready;

    // scaling
    logic [SAMPLE_W-1:0] sample_reg;
    logic [VAL_W-1:0]    scaled;
    logic [VAL_W-1:0]    scaled_reg;

    always_ff @(posedge clk)
    begin
        if (samples.valid && in_ready)
            sample_reg <= samples.sample;
        if (cell_ctrl.load)
            scaled_reg <= scaled;
    end

    pmc_scale u_scale (
        .sample (sample_reg),
        .offset (offset_reg),
        .gain   (gain_reg),
        .invert (invert_reg),
        .scaled (scaled)
    );

    // cell ring
    logic [VAL_W-1:0] circ_val [WINDOW_DEPTH];
    logic [VAL_W-1:0] win_val  [WINDOW_DEPTH];
    logic [CNT_W-1:0] below    [WINDOW_DEPTH];
    logic [CNT_W-1:0] above    [WINDOW_DEPTH];

    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_cell
        pmc_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .wr_sel   (slot_reg == SLOT_W'(k)),
            .wr_value (scaled),
            .circ_in  (circ_val[(k + WINDOW_DEPTH - 1) % WINDOW_DEPTH]),
            .circ_out (circ_val[k]),
            .win_out  (win_val[k]),
            .below    (below[k]),
            .above    (above[k])
        );
    end

    // qualify and pick
    logic [WINDOW_DEPTH-1:0] qual_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_QUAL)
        begin
            for (int k = 0; k < WINDOW_DEPTH; k++)
                qual_reg[k] <= (below[k] <= CNT_W'(HALF)) && (above[k] <= CNT_W'(HALF));
        end
    end

    logic [VAL_W-1:0] med_sel;
    logic             found;

    always_comb
    begin
        med_sel = '0;
        found   = 1'b0;
        for (int k = 0; k < WINDOW_DEPTH; k++)
        begin
            if (!found && qual_reg[k])
            begin
                med_sel = win_val[k];
                found   = 1'b1;
            end
        end
    end

    // report history
    logic [VAL_W-1:0] last_reg;
    logic [VAL_W-1:0] before_reg;
    logic [VAL_W-1:0] count_reg;
    logic             is_new;
    logic             hit;

    assign is_new = (med_sel != last_reg) && (med_sel != before_reg) && report_en_reg;
    assign hit    = is_new && (count_reg == REPORT_PERIOD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '0;
            before_reg <= '0;
            count_reg  <= '0;
        end
        else if (pick_fire && is_new)
        begin
            if (hit)
            begin
                count_reg  <= '0;
                before_reg <= last_reg;
                last_reg   <= med_sel;
            end
            else
                count_reg <= count_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pick_fire)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pick_fire)
        begin
            out_scaled_reg <= scaled_reg;
            out_median_reg <= med_sel;
            out_report_reg <= hit;
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.scaled = out_scaled_reg;
    assign results.median = out_median_reg;
    assign results.report = out_report_reg;

    `PMC_ASSERT_NEXT(a_accept_scale, clk, rst_n, samples.valid && in_ready, state_reg == ST_SCALE)
    `PMC_ASSERT(a_rise_from_pick, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg) == ST_PICK)
    `PMC_ASSERT(a_count_bound, clk, rst_n, count_reg <= REPORT_PERIOD)
    `PMC_ASSERT(a_report_last, clk, rst_n, (out_valid_reg && out_report_reg) |-> (out_median_reg == last_reg))

endmodule

// File: hw/rtl/pmc_scale.sv
// Sample conditioning: offset subtract floored at zero, Q4.8 gain, clamp, invert.
// Depends on pmc_pkg.
module pmc_scale (
    input  logic [pmc_pkg::SAMPLE_W-1:0] sample,
    input  logic [pmc_pkg::SAMPLE_W-1:0] offset,
    input  logic [pmc_pkg::SAMPLE_W-1:0] gain,
    input  logic                         invert,
    output logic [pmc_pkg::VAL_W-1:0]    scaled
);
    import pmc_pkg::*;

    localparam int WHOLE_W = 2*SAMPLE_W - 8;

    logic [SAMPLE_W-1:0]   diff;
    logic [2*SAMPLE_W-1:0] prod;
    logic [WHOLE_W-1:0]    whole;
    logic [VAL_W-1:0]      clamped;

    always_comb
    begin
        diff    = (sample > offset) ? (sample - offset) : '0;
        prod    = diff * gain;
        whole   = prod[2*SAMPLE_W-1:8];
        clamped = (whole > WHOLE_W'(VALUE_MAX)) ? VALUE_MAX : whole[VAL_W-1:0];
        scaled  = invert ? (VALUE_MAX - clamped) : clamped;
    end

endmodule

// File: hw/rtl/pmc_cell.sv
// One window cell: holds an entry, passes a circulating value round the ring
// and counts how many circulating values sit below and above its entry.
// Depends on pmc_pkg.
module pmc_cell #(
    parameter int CNT_W = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pmc_pkg::pmc_cell_ctrl_t    ctrl,
    input  logic                       wr_sel,
    input  logic [pmc_pkg::VAL_W-1:0]  wr_value,
    input  logic [pmc_pkg::VAL_W-1:0]  circ_in,
    output logic [pmc_pkg::VAL_W-1:0]  circ_out,
    output logic [pmc_pkg::VAL_W-1:0]  win_out,
    output logic [CNT_W-1:0]           below,
    output logic [CNT_W-1:0]           above
);
    import pmc_pkg::*;

    logic [VAL_W-1:0] win_reg;
    logic [VAL_W-1:0] win_next;
    logic [VAL_W-1:0] circ_reg;
    logic [VAL_W-1:0] circ_next;
    logic [CNT_W-1:0] below_reg;
    logic [CNT_W-1:0] below_next;
    logic [CNT_W-1:0] above_reg;
    logic [CNT_W-1:0] above_next;

    always_comb
    begin
        win_next   = win_reg;
        circ_next  = circ_reg;
        below_next = below_reg;
        above_next = above_reg;
        if (ctrl.load)
        begin
            win_next   = wr_sel ? wr_value : win_reg;
            circ_next  = win_next;
            below_next = '0;
            above_next = '0;
        end
        else if (ctrl.shift)
        begin
            circ_next  = circ_in;
            below_next = below_reg + {{(CNT_W-1){1'b0}}, (circ_reg < win_reg)};
            above_next = above_reg + {{(CNT_W-1){1'b0}}, (circ_reg > win_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else
            win_reg <= win_next;
    end

    always_ff @(posedge clk)
    begin
        circ_reg  <= circ_next;
        below_reg <= below_next;
        above_reg <= above_next;
    end

    assign circ_out = circ_reg;
    assign win_out  = win_reg;
    assign below    = below_reg;
    assign above    = above_reg;

endmodule

// File: verif/tb_pedal_adc_median_conditioner.sv
// Self-checking testbench for pedal_adc_median_conditioner: directed and random sample streams,
// with config changes between phases, checked against an in-bench model of the conditioner.
// Depends on pmc_pkg, pmc_if and the RTL of the block.
module tb_pedal_adc_median_conditioner;
    timeunit 1ns;
    timeprecision 1ps;

    import pmc_pkg::*;

    localparam int WINDOW_DEPTH = 32;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic [VAL_W-1:0] scaled;
        logic [VAL_W-1:0] median;
        logic             report;
    } pedal_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pmc_sample_if smp_ch ();
    pmc_result_if res_ch ();

    pedal_adc_median_conditioner #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (smp_ch),
        .results   (res_ch)
    );

    // conditioner model state
    logic [SAMPLE_W-1:0] cfg_offset;
    logic [SAMPLE_W-1:0] cfg_gain;
    logic                cfg_invert;
    logic                cfg_report_en;
    logic [VAL_W-1:0]    win [WINDOW_DEPTH];
    int                  slot;
    logic [VAL_W-1:0]    last_report;
    logic [VAL_W-1:0]    prev_report;
    logic [VAL_W-1:0]    change_count;

    logic [SAMPLE_W-1:0] sample_queue [$];
    pedal_result_t       pending_results [$];
    bit                  idling;
    int                  send_gap;
    int                  recv_stall;
    int                  mismatches;
    int                  results_seen;
    int                  cycles;
    int                  pedal_level;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic pedal_result_t condition_sample(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0]   diff;
        logic [2*SAMPLE_W-1:0] product;
        logic [VAL_W-1:0]      level;
        logic [VAL_W-1:0]      mid;
        int                    below;
        int                    above;
        bit                    found;
        pedal_result_t         res;
        diff    = (raw > cfg_offset) ? raw - cfg_offset : '0;
        product = diff * cfg_gain;
        if ((product >> 8) > VALUE_MAX)
            level = VALUE_MAX;
        else
            level = product[VAL_W+7:8];
        if (cfg_invert)
            level = VALUE_MAX - level;
        win[slot] = level;
        slot = (slot == WINDOW_DEPTH - 1) ? 0 : slot + 1;
        mid   = '0;
        found = 1'b0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (!found)
            begin
                below = 0;
                above = 0;
                for (int j = 0; j < WINDOW_DEPTH; j++)
                begin
                    if (win[j] < win[i])
                        below++;
                    else if (win[j] > win[i])
                        above++;
                end
                if (below <= WINDOW_DEPTH / 2 && above <= WINDOW_DEPTH / 2)
                begin
                    mid   = win[i];
                    found = 1'b1;
                end
            end
        end
        res.scaled = level;
        res.median = mid;
        res.report = 1'b0;
        if (mid != last_report && mid != prev_report && cfg_report_en)
        begin
            if (change_count == REPORT_PERIOD)
            begin
                change_count = '0;
                res.report   = 1'b1;
                prev_report  = last_report;
                last_report  = mid;
            end
            else
                change_count = change_count + 1'b1;
        end
        return res;
    endfunction

    // random walk of the pedal with occasional jumps and stray readings
    function automatic logic [SAMPLE_W-1:0] next_pedal_sample();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return SAMPLE_W'($urandom_range(0, 4095));
        if (pick == 1)
            pedal_level = $urandom_range(0, 4095);
        else
            pedal_level += int'($urandom_range(0, 200)) - 100;
        if (pedal_level < 0)
            pedal_level = 0;
        if (pedal_level > 4095)
            pedal_level = 4095;
        return SAMPLE_W'(pedal_level);
    endfunction

    // one-bit register value with random junk above bit 0
    function automatic logic [CFG_DATA_W-1:0] pad_flag(input bit b);
        return {(CFG_DATA_W - 1)'($urandom), b};
    endfunction

    task automatic write_reg(input pmc_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_OFFSET:    cfg_offset    = data;
            REG_GAIN:      cfg_gain      = data;
            REG_INVERT:    cfg_invert    = data[0];
            REG_REPORT_EN: cfg_report_en = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0 || smp_ch.valid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] offs, input logic [CFG_DATA_W-1:0] gn,
                             input bit inv, input bit rep);
        write_reg(REG_OFFSET, offs);
        write_reg(REG_GAIN, gn);
        write_reg(REG_INVERT, pad_flag(inv));
        write_reg(REG_REPORT_EN, pad_flag(rep));
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
            smp_ch.valid <= 1'b0;
        else
        begin
            if (smp_ch.valid && smp_ch.ready)
                pending_results.push_back(condition_sample(smp_ch.sample));
            if (!smp_ch.valid || smp_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    smp_ch.valid <= 1'b0;
                end
                else if (sample_queue.size() == 0)
                    smp_ch.valid <= 1'b0;
                else if (idling && $urandom_range(0, 3) == 0)
                begin
                    send_gap = $urandom_range(0, 2);
                    smp_ch.valid <= 1'b0;
                end
                else
                begin
                    smp_ch.sample <= sample_queue.pop_front();
                    smp_ch.valid  <= 1'b1;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        pedal_result_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("result %0d: transaction with no sample pending", results_seen);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.scaled !== want.scaled || res_ch.median !== want.median
                        || res_ch.report !== want.report)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                            $display("result %0d: expected scaled=%0d median=%0d report=%0b,",
                                     results_seen, want.scaled, want.median, want.report,
                                     " got scaled=%0d median=%0d report=%0b",
                                     res_ch.scaled, res_ch.median, res_ch.report);
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                res_ch.ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                recv_stall = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] offs;
        logic [CFG_DATA_W-1:0] gn;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        res_ch.ready  = 1'b0;
        cfg_offset    = '0;
        cfg_gain      = GAIN_RESET;
        cfg_invert    = 1'b0;
        cfg_report_en = 1'b0;
        foreach (win[i])
            win[i] = '0;
        slot          = 0;
        last_report   = '0;
        prev_report   = '0;
        change_count  = '0;
        idling        = 1'b1;
        pedal_level   = 2048;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: unity gain, plain clamp
        sample_queue = '{12'd0, 12'd4095, 12'd127, 12'd128, 12'd126, 12'd1, 12'hAAA, 12'h555};
        wait_drained();
        // everything floored by the offset, then inverted
        write_all(12'd4095, 12'd4095, 1'b1, 1'b0);
        sample_queue = '{12'd4095, 12'd4094, 12'd0};
        wait_drained();
        // zero gain
        write_all(12'd100, 12'd0, 1'b0, 1'b0);
        sample_queue = '{12'd4095, 12'd100};
        wait_drained();
        // smallest gain, truncation and floor at the offset
        write_all(12'd2000, 12'd1, 1'b0, 1'b0);
        sample_queue = '{12'd4095, 12'd2000, 12'd1999};
        wait_drained();
        // largest gain with saturation, reporting on
        write_all(12'd0, 12'd4095, 1'b0, 1'b1);
        sample_queue = '{12'd1, 12'd2, 12'd5, 12'd4095};

        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            idling = (phase != 4);
            case ($urandom_range(0, 7))
                0:       offs = '0;
                1:       offs = 12'd4095;
                default: offs = CFG_DATA_W'($urandom_range(0, 800));
            endcase
            case ($urandom_range(0, 7))
                0:       gn = '0;
                1:       gn = 12'd4095;
                default: gn = CFG_DATA_W'($urandom_range(4, 64));
            endcase
            if (phase == 4)
                write_all(CFG_DATA_W'($urandom_range(0, 800)),
                          CFG_DATA_W'($urandom_range(4, 64)),
                          1'($urandom_range(0, 1)), 1'b1);
            else
                write_all(offs, gn, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0);
            repeat (80)
                sample_queue.push_back(next_pedal_sample());
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
